[rtl/otea_pkg.sv]
// ----------------------------------------------------------------------------
// otea_pkg: shared types and constants of the offset table entry allocator
// Status codes, command kinds, the queued command record and the sizes of the
// table and of the front/back queue.
// ----------------------------------------------------------------------------
package otea_pkg;

   // Default configuration
   localparam int TABLE_SLOTS_DEF   = 16;
   localparam int VALID_BIT_POS_DEF = 31;

   // Front/back queue depth
   localparam int QUEUE_DEPTH = 2;

   // Field widths
   localparam int ADDR_W   = 52;
   localparam int WORD_W   = 32;
   localparam int PG_W     = 5;
   localparam int FIDX_W   = 8;
   localparam int STATUS_W = 3;
   localparam int EIDX_W   = 4;

   // 2MB span and 256-byte offset granule
   localparam int SPAN_SHIFT = 21;
   localparam int OFS_SHIFT  = 8;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED    = 3'd0,
      ST_NOTHING      = 3'd1,
      ST_BAD_OFFSET   = 3'd2,
      ST_BAD_ARG      = 3'd3,
      ST_FULL         = 3'd4,
      ST_FREE_IGNORED = 3'd5,
      ST_FREED        = 3'd6
   } status_type;

   // What the back end has to do with a queued command
   typedef enum logic [1:0] {
      CMD_REPORT = 2'd0,   // status already decided by the front end
      CMD_ALLOC  = 2'd1,   // arguments passed, claim the lowest free slot
      CMD_FREE   = 2'd2    // release a slot
   } cmd_kind_type;

   // Classified command handed from front to back
   typedef struct packed {
      cmd_kind_type        kind;
      status_type          status;
      logic [FIDX_W-1:0]   free_index;
      logic [ADDR_W:0]     base;         // fabric_base + map_offset
      logic [ADDR_W-1:0]   map_length;
      logic [WORD_W-1:0]   offset_word;
   } cmd_type;

endpackage

[rtl/otea_if.sv]
// ----------------------------------------------------------------------------
// otea_req_if / otea_rsp_if: request and response channels
// Valid/ready channels; a transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface otea_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] sub_page_offset;
   logic [51:0] map_offset;
   logic [51:0] map_length;
   logic [51:0] fabric_size;
   logic [51:0] fabric_base;
   logic        fabric_contiguous;
   logic [4:0]  page_size_log2;
   logic [7:0]  free_index;

   modport source (
      output valid, opcode, sub_page_offset, map_offset, map_length,
             fabric_size, fabric_base, fabric_contiguous, page_size_log2,
             free_index,
      input  ready
   );
   modport sink (
      input  valid, opcode, sub_page_offset, map_offset, map_length,
             fabric_size, fabric_base, fabric_contiguous, page_size_log2,
             free_index,
      output ready
   );
endinterface

interface otea_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  entry_index;
   logic [31:0] start_word;
   logic [31:0] end_word;
   logic [31:0] offset_word;

   modport source (
      output valid, status, entry_index, start_word, end_word, offset_word,
      input  ready
   );
   modport sink (
      input  valid, status, entry_index, start_word, end_word, offset_word,
      output ready
   );
endinterface

[rtl/offset_table_entry_allocator.sv]
// ----------------------------------------------------------------------------
// offset_table_entry_allocator: slot allocator for an address-offset table
// Usage:
//  - req_if carries one request transaction: allocate (opcode 0) or free
//    (opcode 1). rsp_if returns exactly one response transaction per request,
//    in request order.
//  - An allocate is checked (zero offset, page alignment, offset alignment
//    and bound, contiguity, minimum length, range) and then claims the lowest
//    free slot. A free releases an in-range slot that is in use.
//  - A request taken on req_if is written into the command queue; it then
//    loads the output register once that register is empty or draining, and
//    the response is taken from the output register.
//  - Throughput, without stalls: one request per cycle; the back end handles
//    one queued command per cycle, set by the single bitmap search and update.
//  - A two-entry command queue sits between the argument checks and the
//    bitmap; req_if.ready drops only when that queue is full.
//  - When the receiver stalls, the response is held stable in the output
//    register; up to two more requests are absorbed before req_if.ready drops.
//  - Reset marks every slot free, empties the queue and drops rsp_if.valid.
// ----------------------------------------------------------------------------
module offset_table_entry_allocator #(
   parameter int TABLE_SLOTS   = otea_pkg::TABLE_SLOTS_DEF,
   parameter int VALID_BIT_POS = otea_pkg::VALID_BIT_POS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   otea_req_if.sink    req_if,
   otea_rsp_if.source  rsp_if
);
   import otea_pkg::*;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_valid;
   cmd_type q_in_cmd;
   cmd_type q_head_cmd;

   // Intake and checks
   otea_front #(
      .VALID_BIT_POS (VALID_BIT_POS)
   ) u_front (
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_in_cmd)
   );

   // Decoupling queue
   otea_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_cmd  (q_head_cmd)
   );

   // Bitmap and response
   otea_back #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_head_cmd),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

[rtl/otea_front.sv]
// ----------------------------------------------------------------------------
// otea_front: request intake and argument checks
// Accepts request transactions while the queue has room and turns each into a
// classified command: a final status, an allocate or a free.
// ----------------------------------------------------------------------------
module otea_front #(
   parameter int VALID_BIT_POS = otea_pkg::VALID_BIT_POS_DEF
) (
   otea_req_if.sink         req_if,
   input  logic             q_full,
   output logic             q_push,
   output otea_pkg::cmd_type q_cmd
);
   import otea_pkg::*;

   logic [ADDR_W-1:0] page_mask;
   logic [ADDR_W-1:0] last;
   logic [ADDR_W:0]   range_sum;
   logic              fabric_short;
   logic              range_bad;
   logic              arg_bad;

   // Handshake
   assign req_if.ready = !q_full;
   assign q_push       = req_if.valid && !q_full;

   // Page alignment mask, any shift 0..31
   assign page_mask = ADDR_W'((64'd1 << req_if.page_size_log2) - 64'd1);

   // Range must stay below the last 2MB; a fabric under 2MB wraps "last"
   // to a huge value, so the range check then passes.
   assign fabric_short = (req_if.fabric_size[ADDR_W-1:SPAN_SHIFT] == '0);
   assign last         = req_if.fabric_size - (ADDR_W'(1) << SPAN_SHIFT);
   assign range_sum    = {1'b0, req_if.map_offset} + {1'b0, req_if.map_length};
   assign range_bad    = !fabric_short &&
                         ((req_if.map_length > last) || (range_sum > {1'b0, last}));

   assign arg_bad = (req_if.sub_page_offset[OFS_SHIFT-1:0] != '0) ||
                    (req_if.sub_page_offset[WORD_W-1:SPAN_SHIFT] != '0) ||
                    !req_if.fabric_contiguous ||
                    (req_if.map_length[ADDR_W-1:SPAN_SHIFT] == '0) ||
                    range_bad;

   // Classification, first failing check wins
   always_comb begin
      q_cmd             = '0;
      q_cmd.free_index  = req_if.free_index;
      q_cmd.map_length  = req_if.map_length;
      q_cmd.base        = {1'b0, req_if.fabric_base} + {1'b0, req_if.map_offset};
      q_cmd.offset_word = WORD_W'(req_if.sub_page_offset >> OFS_SHIFT) |
                          (WORD_W'(1) << VALID_BIT_POS);
      q_cmd.status      = ST_ALLOCATED;
      if (req_if.opcode) begin
         q_cmd.kind = CMD_FREE;
      end else if (req_if.sub_page_offset == '0) begin
         q_cmd.kind   = CMD_REPORT;
         q_cmd.status = ST_NOTHING;
      end else if ((req_if.map_offset & page_mask) != '0) begin
         q_cmd.kind   = CMD_REPORT;
         q_cmd.status = ST_BAD_OFFSET;
      end else if (arg_bad) begin
         q_cmd.kind   = CMD_REPORT;
         q_cmd.status = ST_BAD_ARG;
      end else begin
         q_cmd.kind = CMD_ALLOC;
      end
   end

endmodule

[rtl/otea_queue.sv]
// ----------------------------------------------------------------------------
// otea_queue: command queue between front and back
// Small register FIFO of classified commands.
// ----------------------------------------------------------------------------
module otea_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  otea_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output otea_pkg::cmd_type head_cmd
);
   import otea_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/otea_back.sv]
// ----------------------------------------------------------------------------
// otea_back: slot bitmap and response register
// Executes queued commands against the free-slot bitmap and holds the result
// in an output register until the response transaction completes.
// ----------------------------------------------------------------------------
module otea_back #(
   parameter int TABLE_SLOTS = otea_pkg::TABLE_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  otea_pkg::cmd_type q_cmd,
   output logic             q_pop,
   otea_rsp_if.source       rsp_if
);
   import otea_pkg::*;

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   logic [TABLE_SLOTS-1:0] free_map_ff, free_map_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [EIDX_W-1:0]      entry_index_ff, entry_index_in;
   logic [WORD_W-1:0]      start_word_ff, start_word_in;
   logic [WORD_W-1:0]      end_word_ff, end_word_in;
   logic [WORD_W-1:0]      offset_word_ff, offset_word_in;

   logic [IDX_W-1:0]       low_idx;
   logic [IDX_W-1:0]       free_idx;
   logic                   free_in_range;
   logic [ADDR_W+1:0]      end_addr;

   // Take the next command when the output register is empty or draining
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_if.ready);

   // Lowest free slot
   always_comb begin
      low_idx = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (free_map_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end

   assign free_in_range = (q_cmd.free_index < FIDX_W'(TABLE_SLOTS));
   assign free_idx      = q_cmd.free_index[IDX_W-1:0];
   assign end_addr      = {1'b0, q_cmd.base} + (ADDR_W+2)'(q_cmd.map_length);

   // Command execution
   always_comb begin
      free_map_in    = free_map_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      status_in      = status_ff;
      entry_index_in = entry_index_ff;
      start_word_in  = start_word_ff;
      end_word_in    = end_word_ff;
      offset_word_in = offset_word_ff;
      if (q_pop) begin
         rsp_valid_in   = 1'b1;
         entry_index_in = '0;
         start_word_in  = '0;
         end_word_in    = '0;
         offset_word_in = '0;
         case (q_cmd.kind)
            CMD_REPORT: begin
               status_in = q_cmd.status;
            end
            CMD_ALLOC: begin
               if (free_map_ff == '0) begin
                  status_in = ST_FULL;
               end else begin
                  status_in            = ST_ALLOCATED;
                  free_map_in[low_idx] = 1'b0;
                  entry_index_in       = EIDX_W'(8'(low_idx));
                  start_word_in        = q_cmd.base[SPAN_SHIFT +: WORD_W];
                  end_word_in          = end_addr[SPAN_SHIFT +: WORD_W];
                  offset_word_in       = q_cmd.offset_word;
               end
            end
            CMD_FREE: begin
               if (!free_in_range || free_map_ff[free_idx]) begin
                  status_in = ST_FREE_IGNORED;
               end else begin
                  status_in             = ST_FREED;
                  free_map_in[free_idx] = 1'b1;
                  entry_index_in        = q_cmd.free_index[EIDX_W-1:0];
               end
            end
            default: begin
               status_in = ST_FREE_IGNORED;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         free_map_ff  <= free_map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      entry_index_ff <= entry_index_in;
      start_word_ff  <= start_word_in;
      end_word_ff    <= end_word_in;
      offset_word_ff <= offset_word_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.entry_index = entry_index_ff;
   assign rsp_if.start_word  = start_word_ff;
   assign rsp_if.end_word    = end_word_ff;
   assign rsp_if.offset_word = offset_word_ff;

endmodule

[rtl/otea_checker.sv]
// ----------------------------------------------------------------------------
// otea_checker: port-level checks of the allocator
// Watches the response channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module otea_checker #(
   parameter int VALID_BIT_POS = otea_pkg::VALID_BIT_POS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [3:0]  rsp_entry_index,
   input logic [31:0] rsp_start_word,
   input logic [31:0] rsp_end_word,
   input logic [31:0] rsp_offset_word
);
   import otea_pkg::*;

   // A stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_entry_index) && $stable(rsp_offset_word))
      else $error("response changed while stalled");

   // No response right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // Only an allocation carries address and offset words
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_ALLOCATED) |->
         (rsp_start_word == '0) && (rsp_end_word == '0) && (rsp_offset_word == '0))
      else $error("words set on a non-allocate response");

   // An allocation marks its offset word valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_ALLOCATED) |-> rsp_offset_word[VALID_BIT_POS])
      else $error("allocated offset word without valid bit");

endmodule

bind offset_table_entry_allocator otea_checker #(
   .VALID_BIT_POS (VALID_BIT_POS)
) u_otea_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_entry_index (rsp_if.entry_index),
   .rsp_start_word  (rsp_if.start_word),
   .rsp_end_word    (rsp_if.end_word),
   .rsp_offset_word (rsp_if.offset_word)
);
